// ----- hdl/iira_pkg.sv -----
// ----------------------------------------------------------------------------
// iira_pkg
// Shared types and constants for the indexed insert/remove array.
// ----------------------------------------------------------------------------
package iira_pkg;

	localparam int CAPACITY = 64;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int WORD_W   = 32;
	localparam int OP_W     = 3;
	localparam int IDX_W    = 7;
	localparam int ST_W     = 2;

	typedef enum logic [OP_W-1:0] {
		OP_READ    = 3'd0,
		OP_WRITE   = 3'd1,
		OP_INSERT  = 3'd2,
		OP_REMOVE  = 3'd3,
		OP_RESIZE  = 3'd4,
		OP_REALLOC = 3'd5,
		OP_ERASE   = 3'd6
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK        = 2'd0,
		ST_RANGE     = 2'd1,
		ST_FULL      = 2'd2,
		ST_TOO_LARGE = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_FROM_LEFT,
		CELL_FROM_RIGHT,
		CELL_CLEAR
	} cell_cmd_t;

	typedef logic signed [WORD_W-1:0] word_t;

endpackage

// ----- hdl/iira_req_if.sv -----
// ----------------------------------------------------------------------------
// iira_req_if
// Request channel: operation, index, value and requested length.
// ----------------------------------------------------------------------------
interface iira_req_if
	import iira_pkg::*;
;
	logic                     valid;
	logic                     ready;
	logic [OP_W-1:0]          operation;
	logic [IDX_W-1:0]         index;
	logic signed [WORD_W-1:0] value;
	logic [IDX_W-1:0]         new_length;

	modport source (output valid, operation, index, value, new_length, input ready);
	modport sink   (input valid, operation, index, value, new_length, output ready);
endinterface

// ----- hdl/iira_rsp_if.sv -----
// ----------------------------------------------------------------------------
// iira_rsp_if
// Response channel: read data, length after the operation and status.
// ----------------------------------------------------------------------------
interface iira_rsp_if
	import iira_pkg::*;
;
	logic                     valid;
	logic                     ready;
	logic signed [WORD_W-1:0] read_data;
	logic [CNT_W-1:0]         current_length;
	logic [ST_W-1:0]          status;

	modport source (output valid, read_data, current_length, status, input ready);
	modport sink   (input valid, read_data, current_length, status, output ready);
endinterface

// ----- hdl/indexed_insert_remove_array_top.sv -----
// ----------------------------------------------------------------------------
// indexed_insert_remove_array_top
// Bounded ordered array of signed words with insert, remove and resize.
// ----------------------------------------------------------------------------
// The array is a row of CAPACITY cells; insert and remove move every later
// cell by one place in the same clock edge, and a new request is accepted
// every cycle while the response register is free or being drained. Each
// request yields one response with the read data (zero unless a successful
// read), the length afterwards and a status. Failed requests leave the
// contents untouched. Slots above the length are always held at zero, so
// growth exposes zero-filled entries.
module indexed_insert_remove_array_top
	import iira_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	iira_req_if.sink   req,
	iira_rsp_if.source rsp
);

	logic             rsp_valid_q;
	word_t            rd_q;
	logic [CNT_W-1:0] len_q;
	status_t          st_q;
	logic [CNT_W-1:0] count_q;

	logic             acc;
	op_t              op;
	status_t          st;
	logic             op_known;
	logic             ok;
	logic [CNT_W-1:0] count_nxt;
	word_t            rd_word;

	word_t            cell_data [CAPACITY];
	word_t            cell_rd   [CAPACITY];

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign acc       = req.valid && req.ready;
	assign op        = op_t'(req.operation);

	always_comb begin
		st        = ST_OK;
		op_known  = 1'b1;
		count_nxt = count_q;
		case (op)
			OP_READ, OP_WRITE: begin
				if (req.index >= count_q) st = ST_RANGE;
			end
			OP_INSERT: begin
				if (req.index > count_q) st = ST_RANGE;
				else if (count_q >= CNT_W'(CAPACITY)) st = ST_FULL;
				else count_nxt = count_q + 1'b1;
			end
			OP_REMOVE: begin
				if (req.index >= count_q) st = ST_RANGE;
				else count_nxt = count_q - 1'b1;
			end
			OP_RESIZE, OP_REALLOC: begin
				if (req.new_length > IDX_W'(CAPACITY)) st = ST_TOO_LARGE;
				else count_nxt = CNT_W'(req.new_length);
			end
			OP_ERASE: begin
				count_nxt = '0;
			end
			default: begin
				op_known = 1'b0;
			end
		endcase
	end

	assign ok = acc && op_known && (st == ST_OK);

	for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
		cell_cmd_t cmd;
		word_t     left_w;
		word_t     right_w;
		logic      sel;
		logic [IDX_W-1:0] pos;

		assign pos = IDX_W'(k);

		if (k == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_left
			assign left_w = cell_data[k-1];
		end

		if (k == CAPACITY - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_right
			assign right_w = cell_data[k+1];
		end

		assign sel = (op == OP_READ) && (req.index == pos);

		always_comb begin
			cmd = CELL_HOLD;
			if (ok) begin
				case (op)
					OP_WRITE: begin
						if (pos == req.index) cmd = CELL_LOAD;
					end
					OP_INSERT: begin
						if (pos == req.index) cmd = CELL_LOAD;
						else if (pos > req.index && pos <= IDX_W'(count_q)) cmd = CELL_FROM_LEFT;
					end
					OP_REMOVE: begin
						if (pos >= req.index && pos < IDX_W'(count_q)) cmd = CELL_FROM_RIGHT;
					end
					OP_RESIZE: begin
						if (pos >= req.new_length) cmd = CELL_CLEAR;
					end
					OP_REALLOC, OP_ERASE: begin
						cmd = CELL_CLEAR;
					end
					default: begin
						cmd = CELL_HOLD;
					end
				endcase
			end
		end

		iira_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.load_value (req.value),
			.left_data  (left_w),
			.right_data (right_w),
			.rd_sel     (sel),
			.data       (cell_data[k]),
			.rd_data    (cell_rd[k])
		);
	end

	always_comb begin
		rd_word = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_word = rd_word | cell_rd[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			count_q     <= '0;
		end else begin
			if (acc) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (ok) begin
				count_q <= count_nxt;
			end
		end
	end

	// response payload
	always_ff @(posedge clk) begin
		if (acc) begin
			rd_q  <= (ok && op == OP_READ) ? rd_word : '0;
			len_q <= ok ? count_nxt : count_q;
			st_q  <= st;
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.read_data      = rd_q;
	assign rsp.current_length = len_q;
	assign rsp.status         = st_q;

endmodule

// ----- hdl/iira_cell.sv -----
// ----------------------------------------------------------------------------
// iira_cell
// One array slot: holds a word, loads, shifts from a neighbor or clears.
// ----------------------------------------------------------------------------
module iira_cell
	import iira_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cell_cmd_t cmd,
	input  word_t     load_value,
	input  word_t     left_data,
	input  word_t     right_data,
	input  logic      rd_sel,
	output word_t     data,
	output word_t     rd_data
);

	word_t data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q <= '0;
		end else begin
			case (cmd)
				CELL_LOAD:       data_q <= load_value;
				CELL_FROM_LEFT:  data_q <= left_data;
				CELL_FROM_RIGHT: data_q <= right_data;
				CELL_CLEAR:      data_q <= '0;
				default:         data_q <= data_q;
			endcase
		end
	end

	assign data    = data_q;
	assign rd_data = rd_sel ? data_q : '0;

endmodule

// ----- dv/iira_checker.sv -----
// ----------------------------------------------------------------------------
// iira_checker
// Watches the request and response channels of the indexed insert/remove
// array, keeps a shadow copy of the array and its length, predicts the
// response of every accepted request and compares each response field by
// field, oldest prediction first.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module iira_checker
	import iira_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	iira_req_if              req,
	iira_rsp_if              rsp,
	output int               fails,
	output int               pending,
	output logic [CNT_W-1:0] fill
);

	typedef struct {
		word_t            rd;
		logic [CNT_W-1:0] len;
		logic [ST_W-1:0]  st;
	} result_t;

	word_t            shadow_cells [CAPACITY];
	int               shadow_len;
	result_t          expected_results [$];
	int               err_count;

	assign fails = err_count;

	task automatic report_mismatch(input string msg);
		$display("[%0t] MISMATCH: %s", $time, msg);
		err_count++;
	endtask

	task automatic apply_request(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
			input word_t val, input logic [IDX_W-1:0] nlen, output result_t res);
		int i;
		int n;
		int ix;
		int nl;
		n = shadow_len;
		ix = idx;
		nl = nlen;
		res.rd = '0;
		res.st = ST_OK;
		case (op)
			OP_READ: begin
				if (ix < n) res.rd = shadow_cells[ix];
				else res.st = ST_RANGE;
			end
			OP_WRITE: begin
				if (ix < n) shadow_cells[ix] = val;
				else res.st = ST_RANGE;
			end
			OP_INSERT: begin
				if (ix > n) begin
					res.st = ST_RANGE;
				end else if (n >= CAPACITY) begin
					res.st = ST_FULL;
				end else begin
					for (i = n; i > ix; i--) shadow_cells[i] = shadow_cells[i-1];
					shadow_cells[ix] = val;
					n++;
				end
			end
			OP_REMOVE: begin
				if (ix >= n) begin
					res.st = ST_RANGE;
				end else begin
					for (i = ix; i + 1 < n; i++) shadow_cells[i] = shadow_cells[i+1];
					n--;
					shadow_cells[n] = '0;
				end
			end
			OP_RESIZE: begin
				if (nl > CAPACITY) begin
					res.st = ST_TOO_LARGE;
				end else begin
					for (i = nl; i < CAPACITY; i++) shadow_cells[i] = '0;
					n = nl;
				end
			end
			OP_REALLOC: begin
				if (nl > CAPACITY) begin
					res.st = ST_TOO_LARGE;
				end else begin
					for (i = 0; i < CAPACITY; i++) shadow_cells[i] = '0;
					n = nl;
				end
			end
			OP_ERASE: begin
				for (i = 0; i < CAPACITY; i++) shadow_cells[i] = '0;
				n = 0;
			end
			default: ;
		endcase
		shadow_len = n;
		res.len = CNT_W'(n);
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t res;
		result_t want;
		int i;
		if (!arst_n) begin
			for (i = 0; i < CAPACITY; i++) shadow_cells[i] = '0;
			shadow_len = 0;
			expected_results.delete();
			err_count = 0;
			pending <= 0;
			fill <= '0;
		end else begin
			if (req.valid && req.ready) begin
				apply_request(req.operation, req.index, req.value, req.new_length, res);
				expected_results.push_back(res);
			end
			if (rsp.valid && rsp.ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("response transaction with no request outstanding");
				end else begin
					want = expected_results.pop_front();
					if (rsp.read_data !== want.rd)
						report_mismatch($sformatf("read_data got %h expected %h",
							rsp.read_data, want.rd));
					if (rsp.current_length !== want.len)
						report_mismatch($sformatf("current_length got %0d expected %0d",
							rsp.current_length, want.len));
					if (rsp.status !== want.st)
						report_mismatch($sformatf("status got %0d expected %0d",
							rsp.status, want.st));
				end
			end
			pending <= expected_results.size();
			fill <= CNT_W'(shadow_len);
		end
	end

endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Testbench top for the indexed insert/remove array. Drives a directed set of
// corner-case requests, then random request sequences shaped around the
// current length, with random idling on both channels in three phases, one
// long response stall and two full drains. Checking is done by iira_checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb
	import iira_pkg::*;
;

	localparam int N_RANDOM    = 1870;
	localparam int PHASE_LEN   = 640;
	localparam int HOLD_AT     = 300;
	localparam int HOLD_CYCLES = 250;
	localparam int PAUSE_AT    = 1000;
	localparam int WATCHDOG    = 5000;
	localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

	logic             clk;
	logic             arst_n;
	int               sent;
	int               quiet = 0;
	int               fails;
	int               pending;
	logic [CNT_W-1:0] fill;

	iira_req_if req ();
	iira_rsp_if rsp ();

	indexed_insert_remove_array_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	iira_checker chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.fails   (fails),
		.pending (pending),
		.fill    (fill)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// idle percentage per channel for the current phase
	function automatic int idle_pct(input bit is_sender, input int n);
		if (n < PHASE_LEN) return is_sender ? 27 : 47;
		if (n < 2 * PHASE_LEN) return is_sender ? 47 : 27;
		return 0;
	endfunction

	task automatic send(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
			input word_t val, input logic [IDX_W-1:0] nlen);
		while ($urandom_range(99) < idle_pct(1'b1, sent)) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid      <= 1'b1;
		req.operation  <= op;
		req.index      <= idx;
		req.value      <= val;
		req.new_length <= nlen;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		sent <= sent + 1;
	endtask

	// response side: random stalls plus one long hold-off
	initial begin : rsp_drain
		bit held;
		held = 1'b0;
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!held && sent >= HOLD_AT) begin
				held = 1'b1;
				rsp.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				rsp.ready <= ($urandom_range(99) >= idle_pct(1'b0, sent));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet <= 0;
			else quiet <= quiet + 1;
			if (quiet >= WATCHDOG) begin
				$display("** indexed_insert_remove_array_top: FAILED **");
				$finish;
			end
		end
	end

	initial begin
		int k;
		int roll;
		int n;
		logic [OP_W-1:0]  op;
		logic [IDX_W-1:0] idx;
		logic [IDX_W-1:0] nlen;
		word_t            val;

		arst_n = 1'b0;
		sent = 0;
		req.valid = 1'b0;
		req.operation = OP_READ;
		req.index = '0;
		req.value = '0;
		req.new_length = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty array
		send(OP_READ, 7'd0, 32'sd0, 7'd0);
		send(OP_WRITE, 7'd0, 32'sd5, 7'd0);
		send(OP_REMOVE, 7'd0, 32'sd0, 7'd0);
		send(OP_INSERT, 7'd1, 32'sd9, 7'd0);
		// build a few entries at the extremes
		send(OP_INSERT, 7'd0, word_t'(32'h7fffffff), 7'd0);
		send(OP_INSERT, 7'd0, word_t'(32'h80000000), 7'd0);
		send(OP_INSERT, 7'd2, word_t'(32'hffffffff), 7'd127);
		send(OP_READ, 7'd0, 32'sd0, 7'd0);
		send(OP_READ, 7'd2, 32'sd0, 7'd0);
		send(OP_READ, 7'd3, 32'sd0, 7'd0);
		send(OP_READ, 7'd127, word_t'(32'hffffffff), 7'd127);
		send(OP_WRITE, 7'd1, 32'sd0, 7'd0);
		send(OP_WRITE, 7'd127, 32'sd1, 7'd0);
		send(OP_REMOVE, 7'd1, 32'sd0, 7'd0);
		send(OP_REMOVE, 7'd1, 32'sd0, 7'd0);
		// grow to capacity, zero fill, full array
		send(OP_RESIZE, 7'd0, 32'sd0, 7'd64);
		send(OP_READ, 7'd63, 32'sd0, 7'd0);
		send(OP_INSERT, 7'd64, 32'sd3, 7'd0);
		send(OP_INSERT, 7'd65, 32'sd3, 7'd0);
		send(OP_RESIZE, 7'd0, 32'sd0, 7'd64);
		send(OP_RESIZE, 7'd0, 32'sd0, 7'd127);
		send(OP_REALLOC, 7'd0, 32'sd0, 7'd65);
		send(OP_REALLOC, 7'd0, 32'sd0, 7'd1);
		send(OP_REMOVE, 7'd0, 32'sd0, 7'd0);
		send(OP_REALLOC, 7'd0, 32'sd0, 7'd3);
		send(OP_RESIZE, 7'd0, 32'sd0, 7'd0);
		send(OP_UNUSED, 7'd127, word_t'(32'hffffffff), 7'd127);
		send(OP_RESIZE, 7'd0, 32'sd0, 7'd2);
		send(OP_ERASE, 7'd127, word_t'(32'hffffffff), 7'd127);

		for (k = 0; k < N_RANDOM; k++) begin
			if (k == PAUSE_AT) begin
				req.valid <= 1'b0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
			end
			n = fill;
			roll = $urandom_range(99);
			val = word_t'($urandom);
			nlen = ($urandom_range(9) == 0) ? IDX_W'($urandom_range(127))
				: IDX_W'($urandom_range(64));
			idx = (n == 0) ? '0 : IDX_W'($urandom_range(n - 1));
			if (roll < 18) op = OP_READ;
			else if (roll < 33) op = OP_WRITE;
			else if (roll < 58) begin
				op = OP_INSERT;
				idx = IDX_W'($urandom_range(n));
			end else if (roll < 78) op = OP_REMOVE;
			else if (roll < 86) op = OP_RESIZE;
			else if (roll < 90) begin
				op = OP_REALLOC;
				if ($urandom_range(3) != 0) nlen = IDX_W'($urandom_range(12));
			end else if (roll < 92) op = OP_ERASE;
			else if (roll < 94) op = OP_UNUSED;
			else begin
				// noise: any code, any index, any length
				op = OP_W'($urandom_range(7));
				idx = IDX_W'($urandom_range(127));
				nlen = IDX_W'($urandom_range(127));
			end
			if ($urandom_range(19) == 0) idx = IDX_W'($urandom_range(127));
			send(op, idx, val, nlen);
		end

		req.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fails == 0) begin
			$display("** indexed_insert_remove_array_top: PASSED **");
		end else begin
			$display("** indexed_insert_remove_array_top: FAILED **");
		end
		$finish;
	end

endmodule
